/* rtl/irc_msg_pkg.sv */
// ----------------------------------------------------------------------------
// irc_msg_pkg
// Shared types, codes and keyword table for the IRC line byte parser.
// ----------------------------------------------------------------------------
package irc_msg_pkg;

    // Parse phase of the current line
    typedef enum logic [2:0] {
        PH_START    = 3'd0,
        PH_PREFIX   = 3'd1,
        PH_CMDWAIT  = 3'd2,
        PH_COMMAND  = 3'd3,
        PH_PSEP     = 3'd4,
        PH_MIDDLE   = 3'd5,
        PH_TRAILING = 3'd6,
        PH_CRWAIT   = 3'd7
    } phase_t;

    // Byte classes
    localparam logic [2:0] CLS_PREFIX_MARK = 3'd0;
    localparam logic [2:0] CLS_PREFIX      = 3'd1;
    localparam logic [2:0] CLS_SPACE       = 3'd2;
    localparam logic [2:0] CLS_COMMAND     = 3'd3;
    localparam logic [2:0] CLS_MIDDLE      = 3'd4;
    localparam logic [2:0] CLS_TRAIL_MARK  = 3'd5;
    localparam logic [2:0] CLS_TRAILING    = 3'd6;
    localparam logic [2:0] CLS_LINE_END    = 3'd7;

    // Special characters
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Keywords; code of keyword k is k+1, code 0 is unknown
    localparam int         NUM_KEYWORDS = 9;
    localparam logic [3:0] CMD_UNKNOWN  = 4'd0;
    localparam logic [2:0] KW_POS_MAX   = 3'd7;

    function automatic logic [2:0] kw_len(input int k);
        logic [2:0] len;
        begin
            case (k)
                7:       len = 3'd5;
                8:       len = 3'd7;
                default: len = 3'd4;
            endcase
            return len;
        end
    endfunction

    // Keyword text, right-justified: first character in the highest used byte
    function automatic logic [63:0] kw_word(input int k);
        logic [63:0] w;
        begin
            case (k)
                0:       w = 64'("PASS");
                1:       w = 64'("NICK");
                2:       w = 64'("USER");
                3:       w = 64'("QUIT");
                4:       w = 64'("JOIN");
                5:       w = 64'("KICK");
                6:       w = 64'("PART");
                7:       w = 64'("NAMES");
                default: w = 64'("PRIVMSG");
            endcase
            return w;
        end
    endfunction

    // Character p of keyword k (only meaningful for p below its length)
    function automatic logic [7:0] kw_char(input int k, input logic [2:0] p);
        logic [63:0] w;
        logic [2:0]  sh;
        begin
            w  = kw_word(k);
            sh = kw_len(k) - 3'd1 - p;
            return w[{sh, 3'b000} +: 8];
        end
    endfunction

endpackage

/* rtl/irc_message_byte_parser.sv */
// ----------------------------------------------------------------------------
// irc_message_byte_parser
// Throughput: one byte per cycle while the downstream side takes results;
// a held result stalls the input. Phase, keyword mask and counter update
// together in a single pass at the input transfer; the result is registered.
// Reset: rst_n asynchronous, active low; clears the line state to start of
// line and empties the result register.
// ----------------------------------------------------------------------------
// Tags every byte of an IRC-style text line with its role, reports the
// matched command keyword on the byte after the command word, counts
// parameters and flags lines that end inside the prefix.
// ----------------------------------------------------------------------------
module irc_message_byte_parser
    import irc_msg_pkg::*;
#(
    parameter int MAX_PARAM_INDEX = 15
)(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] echo_byte, [8] command_done,
                                   // [12:9] command_code, [16:13] param_index,
                                   // [17] malformed, [23:18] zero
    output logic [2:0]  m_tuser,   // [2:0] byte_class
    output logic        m_tlast    // message_end
);

    // Counter saturates at the parameter, but never beyond what 4 bits hold
    localparam int         ParamLimitInt = (MAX_PARAM_INDEX > 15) ? 15 : MAX_PARAM_INDEX;
    localparam logic [3:0] ParamLimit    = 4'(ParamLimitInt);

    // Line state
    phase_t                    phase_reg,  phase_next;
    logic [NUM_KEYWORDS-1:0]   cand_reg,   cand_next;
    logic [2:0]                kwpos_reg,  kwpos_next;
    logic [3:0]                pcnt_reg,   pcnt_next;

    // Result register
    logic        m_tvalid_reg;
    logic [7:0]  echo_reg;
    logic [2:0]  cls_reg,  cls_next;
    logic        done_reg, done_next;
    logic [3:0]  code_reg, code_next;
    logic [3:0]  pidx_reg;
    logic        mend_reg, mend_next;
    logic        bad_reg,  bad_next;

    logic        accept;
    logic        is_end;
    logic        is_space;
    logic        is_colon;
    logic [3:0]  matched;
    logic [NUM_KEYWORDS-1:0] cand_match;
    logic [2:0]  kwpos_inc;
    logic [3:0]  pcnt_inc;

    // Result register frees up as soon as the downstream side takes it
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign is_end   = (s_tdata == CHAR_CR) || (s_tdata == CHAR_LF);
    assign is_space = (s_tdata == CHAR_SPACE);
    assign is_colon = (s_tdata == CHAR_COLON);

    // Keyword mask after one more command byte, and the saturating position
    always_comb
    begin
        for (int k = 0; k < NUM_KEYWORDS; k++)
        begin
            cand_match[k] = cand_reg[k] && (kwpos_reg < kw_len(k)) &&
                            (kw_char(k, kwpos_reg) == s_tdata);
        end
    end
    assign kwpos_inc = (kwpos_reg < KW_POS_MAX) ? kwpos_reg + 3'd1 : kwpos_reg;
    assign pcnt_inc  = (pcnt_reg < ParamLimit) ? pcnt_reg + 4'd1 : pcnt_reg;

    // Lowest-numbered surviving keyword whose length equals the bytes seen
    always_comb
    begin
        matched = CMD_UNKNOWN;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--)
        begin
            if (cand_reg[k] && (kw_len(k) == kwpos_reg))
                matched = 4'(k + 1);
        end
    end

    // Next state and result fields for the byte at the input
    always_comb
    begin
        phase_next = phase_reg;
        cand_next  = cand_reg;
        kwpos_next = kwpos_reg;
        pcnt_next  = pcnt_reg;
        cls_next   = CLS_PREFIX_MARK;
        done_next  = 1'b0;
        code_next  = CMD_UNKNOWN;
        mend_next  = 1'b0;
        bad_next   = 1'b0;

        if (phase_reg == PH_CRWAIT)
        begin
            // byte after CR belongs to the line end whatever it is
            cls_next  = CLS_LINE_END;
            mend_next = 1'b1;
        end
        else if (phase_reg == PH_COMMAND && (is_end || is_space || is_colon))
        begin
            done_next = 1'b1;
            code_next = matched;
            if (is_space)
            begin
                cls_next   = CLS_SPACE;
                phase_next = PH_PSEP;
            end
            else if (is_colon)
            begin
                cls_next   = CLS_TRAIL_MARK;
                pcnt_next  = pcnt_inc;
                phase_next = PH_TRAILING;
            end
            else
            begin
                cls_next = CLS_LINE_END;
            end
        end
        else if (is_end)
        begin
            cls_next = CLS_LINE_END;
            bad_next = (phase_reg == PH_PREFIX);
        end
        else
        begin
            unique case (phase_reg)
                PH_START, PH_CMDWAIT:
                begin
                    if (is_colon && phase_reg == PH_START)
                    begin
                        cls_next   = CLS_PREFIX_MARK;
                        phase_next = PH_PREFIX;
                    end
                    else if (is_space)
                    begin
                        cls_next = CLS_SPACE;
                    end
                    else
                    begin
                        cls_next   = CLS_COMMAND;
                        cand_next  = cand_match;
                        kwpos_next = kwpos_inc;
                        phase_next = PH_COMMAND;
                    end
                end
                PH_PREFIX:
                begin
                    if (is_space)
                    begin
                        cls_next   = CLS_SPACE;
                        phase_next = PH_CMDWAIT;
                    end
                    else
                    begin
                        cls_next = CLS_PREFIX;
                    end
                end
                PH_COMMAND:
                begin
                    cls_next   = CLS_COMMAND;
                    cand_next  = cand_match;
                    kwpos_next = kwpos_inc;
                end
                PH_PSEP:
                begin
                    if (is_space)
                    begin
                        cls_next = CLS_SPACE;
                    end
                    else if (is_colon)
                    begin
                        cls_next   = CLS_TRAIL_MARK;
                        pcnt_next  = pcnt_inc;
                        phase_next = PH_TRAILING;
                    end
                    else
                    begin
                        cls_next   = CLS_MIDDLE;
                        pcnt_next  = pcnt_inc;
                        phase_next = PH_MIDDLE;
                    end
                end
                PH_MIDDLE:
                begin
                    if (is_space)
                    begin
                        cls_next   = CLS_SPACE;
                        phase_next = PH_PSEP;
                    end
                    else
                    begin
                        // a colon inside a middle parameter stays part of it
                        cls_next = CLS_MIDDLE;
                    end
                end
                default:
                begin
                    cls_next = CLS_TRAILING;
                end
            endcase
        end

        // Line end bookkeeping; counter value above is what gets reported
        if (phase_reg == PH_CRWAIT || s_tdata == CHAR_LF)
        begin
            mend_next  = 1'b1;
            phase_next = PH_START;
            cand_next  = '1;
            kwpos_next = '0;
            pcnt_next  = '0;
        end
        else if (s_tdata == CHAR_CR)
        begin
            phase_next = PH_CRWAIT;
        end
    end

    // Line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            cand_reg  <= '1;
            kwpos_reg <= '0;
            pcnt_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cand_reg  <= cand_next;
            kwpos_reg <= kwpos_next;
            pcnt_reg  <= pcnt_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (s_tready)
            m_tvalid_reg <= s_tvalid;
    end

    // Result payload; counter reported after this byte's update. A line-end
    // byte never bumps the counter; the one that closes the line clears it for
    // the next line, so it reports the count as it stood.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            echo_reg <= s_tdata;
            cls_reg  <= cls_next;
            done_reg <= done_next;
            code_reg <= code_next;
            pidx_reg <= (phase_reg == PH_CRWAIT || s_tdata == CHAR_LF) ?
                        pcnt_reg : pcnt_next;
            mend_reg <= mend_next;
            bad_reg  <= bad_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, bad_reg, pidx_reg, code_reg, done_reg, echo_reg};
    assign m_tuser  = cls_reg;
    assign m_tlast  = mend_reg;

endmodule
